// ===== sv/frt_pkg.sv =====
package frt_pkg;

    localparam int ID_SLOTS   = 8;
    localparam int FRAG_SLOTS = 64;
    localparam int SLOT_W     = 3;
    localparam int IDX_W      = 6;
    localparam int MEM_DEPTH  = ID_SLOTS * FRAG_SLOTS;
    localparam int MEM_AW     = SLOT_W + IDX_W;

    localparam logic [3:0] ST_STORED     = 4'd0;
    localparam logic [3:0] ST_SEGMENT    = 4'd1;
    localparam logic [3:0] ST_DUPLICATE  = 4'd2;
    localparam logic [3:0] ST_MISMATCH   = 4'd3;
    localparam logic [3:0] ST_RANGE      = 4'd4;
    localparam logic [3:0] ST_NO_SLOT    = 4'd5;
    localparam logic [3:0] ST_EMPTY      = 4'd6;
    localparam logic [3:0] ST_UNFRAG     = 4'd7;
    localparam logic [3:0] ST_GAP        = 4'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // register the incoming word
        logic decide;    // evaluate the captured word and update the slot table
        logic seg_load;  // start a completion burst
        logic seg_step;  // emit one segment and read the next length
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic burst;     // the decision calls for a burst of segments
        logic seg_last;  // the segment being emitted is the final one
    } t_sts;

endpackage

// ===== sv/frt_ctrl.sv =====
module frt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  frt_pkg::t_sts i_sts,
    output frt_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_LOAD, S_BURST} t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.burst) begin
                    o_cmd.seg_load = 1'b1;
                    n_state        = S_BURST;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BURST: begin
                o_cmd.seg_step = 1'b1;
                if (i_sts.seg_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    a_burst_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.seg_load |=> r_state == S_BURST)
        else $error("burst not entered after load");
    a_capture_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |-> !busy)
        else $error("capture while busy");
    a_decide_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.decide)
        else $error("decide did not follow capture");

endmodule

// ===== sv/frt_datapath.sv =====
module frt_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  frt_pkg::t_cmd i_cmd,
    output frt_pkg::t_sts o_sts,
    input  logic          i_adopt,
    input  logic [31:0]   i_packet_id,
    input  logic [7:0]    i_frag_index,
    input  logic [7:0]    i_frag_total,
    input  logic [15:0]   i_frag_len,
    output logic          o_strobe,
    output logic [3:0]    o_status,
    output logic [2:0]    o_slot,
    output logic [5:0]    o_seg_index,
    output logic [15:0]   o_seg_len,
    output logic [21:0]   o_seg_offset,
    output logic [21:0]   o_combined_len,
    output logic [6:0]    o_received_count,
    output logic          o_last
);

    localparam int NS = frt_pkg::ID_SLOTS;
    localparam int NF = frt_pkg::FRAG_SLOTS;
    localparam int SW = frt_pkg::SLOT_W;
    localparam int IW = frt_pkg::IDX_W;

    // Captured word.
    logic [31:0] r_id;
    logic [7:0]  r_idx;
    logic [7:0]  r_total;
    logic [15:0] r_len;

    // Slot table.
    logic [NS-1:0]  r_open;
    logic [31:0]    r_pid   [NS];
    logic [7:0]     r_exp   [NS];
    logic [6:0]     r_cnt   [NS];
    logic [21:0]    r_sum   [NS];
    logic [NF-1:0]  r_pres  [NS];
    logic [7:0]     r_largest;

    // Length memory.
    logic [15:0] r_mem [frt_pkg::MEM_DEPTH];
    logic [15:0] r_rdata;

    // Burst state.
    logic          r_burst;
    logic [SW-1:0] r_bslot;
    logic [IW:0]   r_bidx;
    logic [7:0]    r_bn;
    logic [21:0]   r_boff;
    logic [21:0]   r_bsum;
    logic [6:0]    r_bcnt;

    // Search over the slot table.
    logic          hit;
    logic [SW-1:0] hit_s;
    logic          has_free;
    logic [SW-1:0] free_s;
    logic          any_open;

    always_comb begin
        hit      = 1'b0;
        hit_s    = '0;
        has_free = 1'b0;
        free_s   = '0;
        any_open = |r_open;
        for (int i = NS - 1; i >= 0; i--) begin
            if (r_open[i] && r_pid[i] == r_id) begin
                hit   = 1'b1;
                hit_s = SW'(i);
            end
            if (!r_open[i]) begin
                has_free = 1'b1;
                free_s   = SW'(i);
            end
        end
    end

    logic [7:0]    new_largest;
    logic [7:0]    eff_total;
    logic [SW-1:0] s;
    logic [NF-1:0] pres_old;
    logic [NF-1:0] pres_new;
    logic [6:0]    cnt_new;
    logic [21:0]   sum_new;
    logic [7:0]    exp_cur;
    logic [NF-1:0] need_mask;
    logic          bad_early;
    logic [3:0]    early_st;
    logic [IW-1:0] idx6;

    assign idx6 = r_idx[IW-1:0];

    always_comb begin
        bad_early = 1'b1;
        early_st  = frt_pkg::ST_EMPTY;
        if (r_len == '0) begin
            early_st = frt_pkg::ST_EMPTY;
        end else if (r_total == '0) begin
            early_st = frt_pkg::ST_UNFRAG;
        end else if (r_idx >= 8'(NF) || r_total > 8'(NF)) begin
            early_st = frt_pkg::ST_RANGE;
        end else begin
            bad_early = 1'b0;
        end
        new_largest = (!any_open || r_total > r_largest) ? r_total : r_largest;
        eff_total   = i_adopt ? new_largest : r_total;
        s           = hit ? hit_s : free_s;
        exp_cur     = hit ? (i_adopt ? new_largest : r_exp[hit_s]) : eff_total;
        pres_old    = hit ? r_pres[s] : '0;
        pres_new    = pres_old | (NF'(1) << idx6);
        cnt_new     = (hit ? r_cnt[s] : 7'd0) + 7'd1;
        sum_new     = (hit ? r_sum[s] : 22'd0) + 22'(r_len);
        need_mask   = '0;
        for (int p = 0; p < NF; p++) begin
            need_mask[p] = (p < int'(exp_cur));
        end
    end

    logic complete;
    assign complete = ((pres_new & need_mask) == need_mask);

    logic [frt_pkg::MEM_AW-1:0] rd_addr;
    logic [IW:0]                nxt_idx;
    assign nxt_idx = r_bidx + 1'b1;
    assign rd_addr = i_cmd.seg_load ? {r_bslot, IW'(0)} : {r_bslot, nxt_idx[IW-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && !bad_early && (hit || has_free)
                && !(hit && exp_cur != eff_total && !i_adopt)
                && !(hit && r_exp[hit_s] != r_total && !i_adopt)
                && !pres_old[idx6]) begin
            r_mem[{s, idx6}] <= r_len;
        end
        if (i_cmd.seg_load || i_cmd.seg_step) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_id    <= i_packet_id;
            r_idx   <= i_frag_index;
            r_total <= i_frag_total;
            r_len   <= i_frag_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open    <= '0;
            r_largest <= '0;
            r_burst   <= 1'b0;
            o_strobe  <= 1'b0;
            for (int i = 0; i < NS; i++) begin
                r_cnt[i]  <= '0;
                r_sum[i]  <= '0;
                r_pres[i] <= '0;
            end
        end else begin
            o_strobe <= 1'b0;
            if (i_cmd.decide) begin
                o_strobe         <= 1'b1;
                o_slot           <= '0;
                o_seg_index      <= '0;
                o_seg_len        <= '0;
                o_seg_offset     <= '0;
                o_combined_len   <= '0;
                o_received_count <= '0;
                o_last           <= 1'b1;
                r_burst          <= 1'b0;
                if (bad_early) begin
                    o_status <= early_st;
                end else begin
                    r_largest <= new_largest;
                    if (i_adopt) begin
                        for (int i = 0; i < NS; i++) begin
                            if (r_open[i]) r_exp[i] <= new_largest;
                        end
                    end
                    if (!hit && !has_free) begin
                        o_status <= frt_pkg::ST_NO_SLOT;
                    end else if (hit && exp_cur != eff_total) begin
                        o_status         <= frt_pkg::ST_MISMATCH;
                        o_slot           <= s;
                        o_combined_len   <= r_sum[s];
                        o_received_count <= r_cnt[s];
                    end else if (pres_old[idx6]) begin
                        o_status         <= frt_pkg::ST_DUPLICATE;
                        o_slot           <= s;
                        o_combined_len   <= r_sum[s];
                        o_received_count <= r_cnt[s];
                    end else begin
                        r_open[s]        <= 1'b1;
                        r_pid[s]         <= r_id;
                        if (!hit) r_exp[s] <= eff_total;
                        r_pres[s]        <= pres_new;
                        r_cnt[s]         <= cnt_new;
                        r_sum[s]         <= sum_new;
                        o_slot           <= s;
                        o_combined_len   <= sum_new;
                        o_received_count <= cnt_new;
                        if ({1'b0, cnt_new} < {1'b0, exp_cur}) begin
                            o_status <= frt_pkg::ST_STORED;
                        end else if (!complete) begin
                            o_status <= frt_pkg::ST_GAP;
                        end else begin
                            // Result words come from the burst instead.
                            o_strobe <= 1'b0;
                            r_burst  <= 1'b1;
                            r_bslot  <= s;
                            r_bn     <= exp_cur;
                            r_bsum   <= sum_new;
                            r_bcnt   <= cnt_new;
                            r_open[s] <= 1'b0;
                            r_pres[s] <= '0;
                            r_cnt[s]  <= '0;
                            r_sum[s]  <= '0;
                        end
                    end
                end
            end
            if (i_cmd.seg_load) begin
                r_bidx <= '0;
                r_boff <= '0;
            end
            if (i_cmd.seg_step) begin
                o_strobe         <= 1'b1;
                o_status         <= frt_pkg::ST_SEGMENT;
                o_slot           <= r_bslot;
                o_seg_index      <= r_bidx[IW-1:0];
                o_seg_len        <= r_rdata;
                o_seg_offset     <= r_boff;
                o_combined_len   <= r_bsum;
                o_received_count <= r_bcnt;
                o_last           <= o_sts.seg_last;
                r_boff           <= r_boff + 22'(r_rdata);
                r_bidx           <= nxt_idx;
                if (o_sts.seg_last) r_burst <= 1'b0;
            end
        end
    end

    assign o_sts.burst    = r_burst;
    assign o_sts.seg_last = ({1'b0, r_bidx} + 8'd1 == r_bn);

    a_no_strobe_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.seg_load |=> !o_strobe)
        else $error("strobe during burst load");
    a_step_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.seg_step |=> o_strobe && o_status == frt_pkg::ST_SEGMENT)
        else $error("segment step without result");
    a_burst_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.seg_load |=> !r_open[r_bslot])
        else $error("slot still open during burst");

endmodule

// ===== sv/fragment_reassembly_tracker_unit.sv =====
// A word is captured at start and evaluated in the decide state, which
// registers its status result. A completed packet then goes through the load
// and burst states and gives one segment per cycle, set by the single read
// port of the length memory. Start is taken only in idle, not while busy.
// Reset (synchronous, active low) closes every slot; the receiver cannot stall.
module fragment_reassembly_tracker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_adopt_largest_total,
    input  logic [31:0] i_packet_id,
    input  logic [7:0]  i_frag_index,
    input  logic [7:0]  i_frag_total,
    input  logic [15:0] i_frag_len,
    output logic        o_strobe,
    output logic [3:0]  o_status,
    output logic [2:0]  o_slot,
    output logic [5:0]  o_seg_index,
    output logic [15:0] o_seg_len,
    output logic [21:0] o_seg_offset,
    output logic [21:0] o_combined_len,
    output logic [6:0]  o_received_count,
    output logic        o_last
);

    frt_pkg::t_cmd cmd;
    frt_pkg::t_sts sts;
    logic          r_adopt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adopt <= 1'b0;
        end else if (i_cfg_valid) begin
            r_adopt <= i_cfg_adopt_largest_total;
        end
    end

    frt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    frt_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_adopt          (r_adopt),
        .i_packet_id      (i_packet_id),
        .i_frag_index     (i_frag_index),
        .i_frag_total     (i_frag_total),
        .i_frag_len       (i_frag_len),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_slot           (o_slot),
        .o_seg_index      (o_seg_index),
        .o_seg_len        (o_seg_len),
        .o_seg_offset     (o_seg_offset),
        .o_combined_len   (o_combined_len),
        .o_received_count (o_received_count),
        .o_last           (o_last)
    );

endmodule
